/* rtl/core/box_frustum_outcode_classifier_defines.svh */
// assertion helpers for the box outcode classifier
`ifndef BOX_FRUSTUM_OUTCODE_CLASSIFIER_DEFINES_SVH
`define BOX_FRUSTUM_OUTCODE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BFOC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfoc assertion failed");

// next-cycle implication
`define BFOC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfoc assertion failed");

`endif

/* rtl/core/bfoc_pkg.sv */
package bfoc_pkg;

    localparam int CORNERS     = 8;
    localparam int IDX_W       = (CORNERS > 1) ? $clog2(CORNERS) : 1;
    localparam int NUM_PLANES  = 4;
    localparam int NUM_CFG     = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = $clog2(8 * NUM_CFG);
    localparam int CFG_IDX_LSB = 3;

    localparam int COORD_W     = 32;
    localparam int NORMAL_W    = 16;
    localparam int NORMAL_FRAC = 14;
    localparam int PROD_W      = COORD_W + NORMAL_W;
    localparam int DOT_W       = PROD_W + 2;
    localparam int CODE_W      = 6;

    localparam logic signed [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [CODE_W-1:0] ALL_CODE = {CODE_W{1'b1}};

    typedef enum logic [2:0] {
        CFG_PLANE0_NORMAL = 3'd0,
        CFG_PLANE1_NORMAL = 3'd1,
        CFG_PLANE2_NORMAL = 3'd2,
        CFG_PLANE3_NORMAL = 3'd3,
        CFG_OFFSETS_LOW   = 3'd4,
        CFG_OFFSETS_HIGH  = 3'd5,
        CFG_NEAR_DEPTH    = 3'd6,
        CFG_FAR_DEPTH     = 3'd7
    } t_cfg_reg;

    typedef enum logic {
        KIND_CORNER     = 1'b0,
        KIND_LOAD_BOUND = 1'b1
    } t_kind;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] corner_x;
        logic signed [COORD_W-1:0] corner_y;
        logic signed [COORD_W-1:0] corner_z;
        logic signed [COORD_W-1:0] near_bound_load;
        logic signed [COORD_W-1:0] far_bound_load;
    } t_in_beat;

    typedef struct packed {
        logic [CODE_W:0]           outcode;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_z;
        logic signed [COORD_W-1:0] near_bound_now;
        logic signed [COORD_W-1:0] far_bound_now;
    } t_out_beat;

endpackage

/* rtl/core/box_frustum_outcode_classifier.sv */
// box frustum outcode classifier
//
// input channel: one beat per box corner (kind 0) or a running depth bound load
// (kind 1). i_in_valid / o_in_stall; a beat is taken when valid and not stalled.
// output channel: one beat per finished box, after every CORNERS-th corner beat,
// carrying the ORed outcode, the culled flag in bit 6, the box z range (0 when
// culled) and the running near/far bounds. o_out_valid / i_out_stall.
// plane normals, offsets and the near/far limits are written over the apb port
// (64-bit data, register i at byte address 8*i); the user must write them only
// while the block is idle, which the block itself does not enforce.
// throughput: one beat per cycle when nothing stalls. three register stages: input
// register, the twelve 32x16 normal products, then the dot sums, compares and box
// accumulators feeding the output register. the result of a box's last corner
// goes from the input register through the products into the output register.
// a held output only blocks the last corner of the next box; other corners and
// bound loads keep flowing, so the input stalls only once every stage is full.
// reset (synchronous, i_rst_n low) empties the pipe, clears the box
// accumulators, sets the running bounds to the Q16.16 extremes and zeroes the
// configuration registers.
`include "box_frustum_outcode_classifier_defines.svh"

module box_frustum_outcode_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bfoc_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bfoc_pkg::t_out_beat                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfoc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [bfoc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bfoc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import bfoc_pkg::*;

    // configuration
    logic [3*NORMAL_W-1:0] r_normal [NUM_PLANES];
    logic [CFG_DATA_W-1:0] r_off_lo;
    logic [CFG_DATA_W-1:0] r_off_hi;
    logic [COORD_W-1:0]    r_near_d;
    logic [COORD_W-1:0]    r_far_d;

    t_cfg_reg cfg_idx;
    logic     cfg_wr;

    // pipeline
    logic     r_a_valid;
    t_in_beat r_a;

    logic                      r_b_valid;
    logic                      r_b_kind;
    logic signed [COORD_W-1:0] r_b_z;
    logic signed [COORD_W-1:0] r_b_near_load;
    logic signed [COORD_W-1:0] r_b_far_load;
    logic [1:0]                r_b_zcode;
    logic signed [PROD_W-1:0]  r_prod [NUM_PLANES][3];
    logic signed [PROD_W-1:0]  n_prod [NUM_PLANES][3];
    logic [1:0]                n_zcode;

    // box and running state
    logic [IDX_W-1:0]          r_corner_idx;
    logic [CODE_W-1:0]         r_any_code;
    logic [CODE_W-1:0]         r_all_code;
    logic signed [COORD_W-1:0] r_box_lo;
    logic signed [COORD_W-1:0] r_box_hi;
    logic signed [COORD_W-1:0] r_run_near;
    logic signed [COORD_W-1:0] r_run_far;

    logic      r_out_valid;
    t_out_beat r_out;

    logic signed [COORD_W-1:0] plane_off [NUM_PLANES];
    logic signed [DOT_W-1:0]   dot       [NUM_PLANES];
    logic [CODE_W-1:0]         code;
    logic [CODE_W-1:0]         n_any;
    logic [CODE_W-1:0]         n_all;
    logic signed [COORD_W-1:0] n_lo;
    logic signed [COORD_W-1:0] n_hi;
    logic                      c_last;
    logic                      culled;
    logic                      out_free;
    logic                      fire_c;
    logic                      adv_a;
    t_out_beat                 n_out;

    // ---------------- apb
    assign cfg_idx = t_cfg_reg'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_normal[p] <= '0;
            end
            r_off_lo <= '0;
            r_off_hi <= '0;
            r_near_d <= '0;
            r_far_d  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_PLANE0_NORMAL: r_normal[0] <= pwdata[3*NORMAL_W-1:0];
                CFG_PLANE1_NORMAL: r_normal[1] <= pwdata[3*NORMAL_W-1:0];
                CFG_PLANE2_NORMAL: r_normal[2] <= pwdata[3*NORMAL_W-1:0];
                CFG_PLANE3_NORMAL: r_normal[3] <= pwdata[3*NORMAL_W-1:0];
                CFG_OFFSETS_LOW:   r_off_lo    <= pwdata;
                CFG_OFFSETS_HIGH:  r_off_hi    <= pwdata;
                CFG_NEAR_DEPTH:    r_near_d    <= pwdata[COORD_W-1:0];
                CFG_FAR_DEPTH:     r_far_d     <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_PLANE0_NORMAL: prdata = CFG_DATA_W'(r_normal[0]);
            CFG_PLANE1_NORMAL: prdata = CFG_DATA_W'(r_normal[1]);
            CFG_PLANE2_NORMAL: prdata = CFG_DATA_W'(r_normal[2]);
            CFG_PLANE3_NORMAL: prdata = CFG_DATA_W'(r_normal[3]);
            CFG_OFFSETS_LOW:   prdata = r_off_lo;
            CFG_OFFSETS_HIGH:  prdata = r_off_hi;
            CFG_NEAR_DEPTH:    prdata = CFG_DATA_W'(r_near_d);
            CFG_FAR_DEPTH:     prdata = CFG_DATA_W'(r_far_d);
            default:           prdata = '0;
        endcase
    end

    // ---------------- flow control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign c_last     = (r_b_kind == KIND_CORNER) && (r_corner_idx == IDX_W'(CORNERS - 1));
    assign fire_c     = r_b_valid && (!c_last || out_free);
    assign adv_a      = r_a_valid && (!r_b_valid || fire_c);
    assign o_in_stall = r_a_valid && !adv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_a <= i_in_data;
        end
    end

    // ---------------- products and depth limit compares
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            n_prod[p][0] = PROD_W'(r_a.corner_x) * PROD_W'($signed(r_normal[p][15:0]));
            n_prod[p][1] = PROD_W'(r_a.corner_y) * PROD_W'($signed(r_normal[p][31:16]));
            n_prod[p][2] = PROD_W'(r_a.corner_z) * PROD_W'($signed(r_normal[p][47:32]));
        end
        n_zcode[1] = r_a.corner_z > $signed(r_far_d);
        n_zcode[0] = r_a.corner_z < $signed(r_near_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (!r_b_valid || fire_c) begin
            r_b_valid <= adv_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_b_kind      <= r_a.kind;
            r_b_z         <= r_a.corner_z;
            r_b_near_load <= r_a.near_bound_load;
            r_b_far_load  <= r_a.far_bound_load;
            r_b_zcode     <= n_zcode;
            r_prod        <= n_prod;
        end
    end

    // ---------------- plane compares and box accumulation
    assign plane_off[0] = $signed(r_off_lo[31:0]);
    assign plane_off[1] = $signed(r_off_lo[63:32]);
    assign plane_off[2] = $signed(r_off_hi[31:0]);
    assign plane_off[3] = $signed(r_off_hi[63:32]);

    always_comb begin
        code[CODE_W-1 -: 2] = r_b_zcode;
        for (int p = 0; p < NUM_PLANES; p++) begin
            dot[p] = DOT_W'(r_prod[p][0]) + DOT_W'(r_prod[p][1]) + DOT_W'(r_prod[p][2]);
            // dot / 2^14 < off  <=>  dot < off * 2^14
            code[p] = dot[p] < (DOT_W'(plane_off[p]) <<< NORMAL_FRAC);
        end
        n_any  = r_any_code | code;
        n_all  = r_all_code & code;
        n_lo   = (r_b_z < r_box_lo) ? r_b_z : r_box_lo;
        n_hi   = (r_b_z > r_box_hi) ? r_b_z : r_box_hi;
        culled = n_all != '0;

        n_out.outcode = {culled, n_any};
        if (culled) begin
            n_out.box_min_z      = '0;
            n_out.box_max_z      = '0;
            n_out.near_bound_now = r_run_near;
            n_out.far_bound_now  = r_run_far;
        end else begin
            n_out.box_min_z      = n_lo;
            n_out.box_max_z      = n_hi;
            n_out.near_bound_now = (r_run_near > n_lo) ? n_lo : r_run_near;
            n_out.far_bound_now  = (r_run_far < n_hi) ? n_hi : r_run_far;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_idx <= '0;
            r_any_code   <= '0;
            r_all_code   <= ALL_CODE;
            r_box_lo     <= Q_MAX;
            r_box_hi     <= Q_MIN;
            r_run_near   <= Q_MAX;
            r_run_far    <= Q_MIN;
        end else if (fire_c) begin
            if (r_b_kind == KIND_LOAD_BOUND) begin
                r_run_near <= r_b_near_load;
                r_run_far  <= r_b_far_load;
            end else if (c_last) begin
                r_corner_idx <= '0;
                r_any_code   <= '0;
                r_all_code   <= ALL_CODE;
                r_box_lo     <= Q_MAX;
                r_box_hi     <= Q_MIN;
                r_run_near   <= n_out.near_bound_now;
                r_run_far    <= n_out.far_bound_now;
            end else begin
                r_corner_idx <= r_corner_idx + 1'b1;
                r_any_code   <= n_any;
                r_all_code   <= n_all;
                r_box_lo     <= n_lo;
                r_box_hi     <= n_hi;
            end
        end
    end

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_c && c_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_c && c_last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- checks
    `BFOC_ASSERT_NOW(a_culled_zero_range, r_out_valid && r_out.outcode[CODE_W], (r_out.box_min_z == '0) && (r_out.box_max_z == '0))
    `BFOC_ASSERT_NOW(a_bounds_cover_box, r_out_valid && !r_out.outcode[CODE_W], (r_out.near_bound_now <= r_out.box_min_z) && (r_out.far_bound_now >= r_out.box_max_z) && (r_out.box_min_z <= r_out.box_max_z))
    `BFOC_ASSERT_NEXT(a_box_cleared, fire_c && c_last, (r_corner_idx == '0) && (r_all_code == ALL_CODE) && (r_any_code == '0) && r_out_valid)

endmodule
